>>> rtl/vertex_layout_decode_unit_macros.svh
// assertion macros used by the checker of the vertex layout decoder
`ifndef VERTEX_LAYOUT_DECODE_UNIT_MACROS_SVH
`define VERTEX_LAYOUT_DECODE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define VLD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vertex layout decode check failed");

// next-cycle implication, sampled on clk, off during reset
`define VLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vertex layout decode check failed");

`endif

>>> rtl/vld_pkg.sv
package vld_pkg;

  typedef logic [6:0] cursor_t;
  typedef logic [2:0] align_t;
  typedef logic [7:0] offset_t;

  localparam offset_t ABSENT_OFFSET = 8'hff;
  localparam logic [2:0] COLOR_FULL = 3'd7;

  localparam logic [1:0] SCALAR_BYTE  = 2'd1;
  localparam logic [1:0] SCALAR_HALF  = 2'd2;
  localparam logic [1:0] SCALAR_FLOAT = 2'd3;

  // fields that pass through the pipe untouched
  typedef struct packed {
    logic [3:0] wgt_num;
    logic [3:0] morph_num;
    logic       through_mode;
    logic [1:0] index_code;
  } misc_t;

  // bytes per scalar for a component code, 0 when absent
  function automatic align_t scalar_bytes(input logic [1:0] code);
    align_t r;
    case (code)
      SCALAR_BYTE:  r = 3'd1;
      SCALAR_HALF:  r = 3'd2;
      SCALAR_FLOAT: r = 3'd4;
      default:      r = 3'd0;
    endcase
    return r;
  endfunction

  // round a byte cursor up to an alignment of 1, 2 or 4
  function automatic cursor_t round_up(input cursor_t v, input align_t a);
    cursor_t r;
    case (a)
      3'd2:    r = (v + 7'd1) & 7'h7e;
      3'd4:    r = (v + 7'd3) & 7'h7c;
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/vertex_layout_decode_unit.sv
// Vertex layout decoder.
// Input channel: vertex_type with in_valid / in_stall; a transfer happens at a
// clock edge where in_valid is high and in_stall is low.
// Output channel: the five component byte offsets (255 when absent), stride,
// wgt_num, morph_num, through_mode, index_code and drawable, with
// out_valid / out_stall.
// Three register stages, stage 1, stage 2 and the output register, lie between
// the input transfer and out_valid; one vertex type is taken every cycle
// while in_stall is low. The stages place weights and texture, then color and
// normal, then position and the padded stride.
// Each stage moves on when the stage after it is empty or moving, so a stall
// at the output fills the empty stages first and in_stall only rises once
// all three stages hold items. Held results do not change under stall.
// A vertex type with no position gives drawable 0, all offsets 255 and
// stride 0.
// Reset (rst, synchronous) empties all stages; out_valid is low after it.
module vertex_layout_decode_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [23:0]      vertex_type,
  output logic             out_valid,
  input  logic             out_stall,
  output vld_pkg::offset_t wgt_ofs,
  output vld_pkg::offset_t tex_ofs,
  output vld_pkg::offset_t col_ofs,
  output vld_pkg::offset_t nrm_ofs,
  output vld_pkg::offset_t pos_ofs,
  output logic [6:0]       stride,
  output logic [3:0]       wgt_num,
  output logic [3:0]       morph_num,
  output logic             through_mode,
  output logic [1:0]       index_code,
  output logic             drawable
);
  import vld_pkg::*;

  // stage registers
  logic    s1_valid;
  logic    s2_valid;
  offset_t s1_w_off, s1_t_off;
  cursor_t s1_cursor;
  align_t  s1_widest;
  logic [2:0] s1_col;
  logic [1:0] s1_nrm, s1_pos;
  misc_t   s1_misc;
  offset_t s2_w_off, s2_t_off, s2_c_off, s2_n_off;
  cursor_t s2_cursor;
  align_t  s2_widest;
  logic [1:0] s2_pos;
  misc_t   s2_misc;

  // advance enables
  logic adv1, adv2, adv3;
  assign adv3     = !out_valid || !out_stall;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_stall = !adv1;

  // stage 1 logic: weights then texture
  align_t  w_sc, t_sc, s1_widest_next;
  cursor_t w_size, t_start, s1_cursor_next;
  offset_t s1_w_off_next, s1_t_off_next;
  misc_t   s1_misc_next;
  always_comb begin
    s1_misc_next.wgt_num      = {1'b0, vertex_type[16:14]} + 4'd1;
    s1_misc_next.morph_num    = {1'b0, vertex_type[20:18]} + 4'd1;
    s1_misc_next.through_mode = vertex_type[23];
    s1_misc_next.index_code   = vertex_type[12:11];
    w_sc   = scalar_bytes(vertex_type[10:9]);
    t_sc   = scalar_bytes(vertex_type[1:0]);
    w_size = 7'(w_sc) * 7'(s1_misc_next.wgt_num);
    s1_widest_next = 3'd1;
    s1_w_off_next  = ABSENT_OFFSET;
    if (w_sc != 3'd0) begin
      s1_w_off_next = 8'd0;
      if (w_sc > s1_widest_next) s1_widest_next = w_sc;
    end
    t_start        = round_up(w_size, t_sc);
    s1_t_off_next  = ABSENT_OFFSET;
    s1_cursor_next = w_size;
    if (t_sc != 3'd0) begin
      s1_t_off_next  = {1'b0, t_start};
      s1_cursor_next = t_start + {3'd0, t_sc, 1'b0};
      if (t_sc > s1_widest_next) s1_widest_next = t_sc;
    end
  end

  // stage 2 logic: color then normal
  align_t  c_sz, n_sc, s2_widest_next;
  cursor_t c_start, c_end, n_start, s2_cursor_next;
  offset_t s2_c_off_next, s2_n_off_next;
  always_comb begin
    if (s1_col == COLOR_FULL) c_sz = 3'd4;
    else if (s1_col[2])       c_sz = 3'd2;
    else                      c_sz = 3'd0;
    n_sc           = scalar_bytes(s1_nrm);
    s2_widest_next = s1_widest;
    c_start        = round_up(s1_cursor, c_sz);
    s2_c_off_next  = ABSENT_OFFSET;
    c_end          = s1_cursor;
    if (c_sz != 3'd0) begin
      s2_c_off_next = {1'b0, c_start};
      c_end         = c_start + 7'(c_sz);
      if (c_sz > s2_widest_next) s2_widest_next = c_sz;
    end
    n_start        = round_up(c_end, n_sc);
    s2_n_off_next  = ABSENT_OFFSET;
    s2_cursor_next = c_end;
    if (n_sc != 3'd0) begin
      s2_n_off_next  = {1'b0, n_start};
      s2_cursor_next = n_start + {3'd0, n_sc, 1'b0} + 7'(n_sc);
      if (n_sc > s2_widest_next) s2_widest_next = n_sc;
    end
  end

  // stage 3 logic: position and padded stride
  align_t  p_sc, widest3;
  cursor_t p_start, p_end;
  always_comb begin
    p_sc    = scalar_bytes(s2_pos);
    widest3 = (p_sc > s2_widest) ? p_sc : s2_widest;
    p_start = round_up(s2_cursor, p_sc);
    p_end   = p_start + {3'd0, p_sc, 1'b0} + 7'(p_sc);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid  <= in_valid;
      if (adv2) s2_valid  <= s1_valid;
      if (adv3) out_valid <= s2_valid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_w_off  <= s1_w_off_next;
      s1_t_off  <= s1_t_off_next;
      s1_cursor <= s1_cursor_next;
      s1_widest <= s1_widest_next;
      s1_col    <= vertex_type[4:2];
      s1_nrm    <= vertex_type[6:5];
      s1_pos    <= vertex_type[8:7];
      s1_misc   <= s1_misc_next;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_w_off  <= s1_w_off;
      s2_t_off  <= s1_t_off;
      s2_c_off  <= s2_c_off_next;
      s2_n_off  <= s2_n_off_next;
      s2_cursor <= s2_cursor_next;
      s2_widest <= s2_widest_next;
      s2_pos    <= s1_pos;
      s2_misc   <= s1_misc;
    end
  end

  // output register, blanked layout when there is no position
  always_ff @(posedge clk) begin
    if (adv3) begin
      wgt_num      <= s2_misc.wgt_num;
      morph_num    <= s2_misc.morph_num;
      through_mode <= s2_misc.through_mode;
      index_code   <= s2_misc.index_code;
      if (p_sc != 3'd0) begin
        wgt_ofs  <= s2_w_off;
        tex_ofs  <= s2_t_off;
        col_ofs  <= s2_c_off;
        nrm_ofs  <= s2_n_off;
        pos_ofs  <= {1'b0, p_start};
        stride   <= round_up(p_end, widest3);
        drawable <= 1'b1;
      end else begin
        wgt_ofs  <= ABSENT_OFFSET;
        tex_ofs  <= ABSENT_OFFSET;
        col_ofs  <= ABSENT_OFFSET;
        nrm_ofs  <= ABSENT_OFFSET;
        pos_ofs  <= ABSENT_OFFSET;
        stride   <= 7'd0;
        drawable <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/vld_checker.sv
`include "vertex_layout_decode_unit_macros.svh"

module vld_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input vld_pkg::offset_t wgt_ofs,
  input vld_pkg::offset_t pos_ofs,
  input logic [6:0]       stride,
  input logic [3:0]       wgt_num,
  input logic [3:0]       morph_num,
  input logic             drawable
);
  import vld_pkg::*;

  // a stalled result stays offered
  `VLD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // with nothing at the output the pipe has room for a transfer
  `VLD_ASSERT_NOW(a_empty_no_stall, !out_valid, !in_stall)

  // a vertex without position carries the blank layout
  `VLD_ASSERT_NOW(a_blank_layout, out_valid && !drawable,
                  stride == 7'd0 && pos_ofs == ABSENT_OFFSET &&
                  wgt_ofs == ABSENT_OFFSET)

  // a drawable vertex always has a placed position, a nonzero stride and nonzero weight and morph counts
  `VLD_ASSERT_NOW(a_drawable_layout, out_valid && drawable,
                  stride != 7'd0 && pos_ofs != ABSENT_OFFSET &&
                  wgt_num != 4'd0 && morph_num != 4'd0)

endmodule

bind vertex_layout_decode_unit vld_checker u_vld_checker (.*);

>>> test/testbench.sv
// one expected or observed vertex layout
typedef struct {
  vld_pkg::offset_t wgt_ofs;
  vld_pkg::offset_t tex_ofs;
  vld_pkg::offset_t col_ofs;
  vld_pkg::offset_t nrm_ofs;
  vld_pkg::offset_t pos_ofs;
  logic [6:0]       stride;
  logic [3:0]       wgt_num;
  logic [3:0]       morph_num;
  logic             through_mode;
  logic [1:0]       index_code;
  logic             drawable;
} layout_t;

// tracks expected layouts for accepted vertex types and checks results in order
class layout_scoreboard;

  // color codes 4 to 6 are 16-bit packed forms
  localparam logic [2:0] COLOR_PACKED_MIN = 3'd4;

  layout_t     pending[$];
  int unsigned errors;
  int unsigned noted;
  int unsigned checked;
  int unsigned drawn;

  // bytes per scalar of a component code, 0 when the component is absent
  function int unsigned scalar_size(logic [1:0] code);
    case (code)
      vld_pkg::SCALAR_BYTE:  return 1;
      vld_pkg::SCALAR_HALF:  return 2;
      vld_pkg::SCALAR_FLOAT: return 4;
      default:               return 0;
    endcase
  endfunction

  function int unsigned pad_to(int unsigned v, int unsigned a);
    if (a <= 1) begin
      return v;
    end
    return (v + a - 1) / a * a;
  endfunction

  // lay out weights, texture, color, normal, position in that order
  function layout_t predict_layout(logic [23:0] vt);
    layout_t          r;
    int unsigned      sz[5];
    int unsigned      al[5];
    vld_pkg::offset_t offs[5];
    int unsigned      cursor;
    int unsigned      widest;
    int               i;
    r.wgt_num      = {1'b0, vt[16:14]} + 4'd1;
    r.morph_num    = {1'b0, vt[20:18]} + 4'd1;
    r.through_mode = vt[23];
    r.index_code   = vt[12:11];
    r.drawable     = (vt[8:7] != vld_pkg::SCALAR_BYTE - 2'd1);
    al[0] = scalar_size(vt[10:9]);
    sz[0] = al[0] * (vt[16:14] + 1);
    al[1] = scalar_size(vt[1:0]);
    sz[1] = al[1] * 2;
    if (vt[4:2] == vld_pkg::COLOR_FULL) begin
      al[2] = 4;
    end else if (vt[4:2] >= COLOR_PACKED_MIN) begin
      al[2] = 2;
    end else begin
      al[2] = 0;
    end
    sz[2] = al[2];
    al[3] = scalar_size(vt[6:5]);
    sz[3] = al[3] * 3;
    al[4] = scalar_size(vt[8:7]);
    sz[4] = al[4] * 3;
    cursor = 0;
    widest = 1;
    for (i = 0; i < 5; i++) begin
      offs[i] = vld_pkg::ABSENT_OFFSET;
      if (r.drawable && sz[i] != 0) begin
        cursor  = pad_to(cursor, al[i]);
        offs[i] = cursor[7:0];
        cursor += sz[i];
        if (al[i] > widest) begin
          widest = al[i];
        end
      end
    end
    r.wgt_ofs = offs[0];
    r.tex_ofs = offs[1];
    r.col_ofs = offs[2];
    r.nrm_ofs = offs[3];
    r.pos_ofs = offs[4];
    r.stride  = r.drawable ? 7'(pad_to(cursor, widest)) : 7'd0;
    return r;
  endfunction

  function void note(logic [23:0] vt);
    pending.push_back(predict_layout(vt));
    noted++;
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task compare(string name, int unsigned got, int unsigned want);
    if (got != want) begin
      report($sformatf("%s got %0d, want %0d", name, got, want));
    end
  endtask

  // compare one accepted result against the oldest expected layout
  task check(layout_t got);
    layout_t want;
    if (pending.size() == 0) begin
      report("result transfer with no vertex type pending");
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got.drawable) begin
      drawn++;
    end
    compare("wgt_ofs", got.wgt_ofs, want.wgt_ofs);
    compare("tex_ofs", got.tex_ofs, want.tex_ofs);
    compare("col_ofs", got.col_ofs, want.col_ofs);
    compare("nrm_ofs", got.nrm_ofs, want.nrm_ofs);
    compare("pos_ofs", got.pos_ofs, want.pos_ofs);
    compare("stride", got.stride, want.stride);
    compare("wgt_num", got.wgt_num, want.wgt_num);
    compare("morph_num", got.morph_num, want.morph_num);
    compare("through_mode", got.through_mode, want.through_mode);
    compare("index_code", got.index_code, want.index_code);
    compare("drawable", got.drawable, want.drawable);
  endtask

endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  SCALAR_NONE    = 2'd0;
  localparam logic [2:0]  COLOR_NONE     = 3'd0;
  localparam logic [2:0]  COLOR_PACKED   = 3'd5;
  localparam logic [1:0]  INDEX_NONE     = 2'd0;
  localparam logic [1:0]  INDEX_BYTE     = 2'd1;
  localparam logic [1:0]  INDEX_HALF     = 2'd2;
  localparam logic [1:0]  INDEX_RESERVED = 2'd3;
  localparam logic [23:0] UNUSED_BITS    = 24'h622000;
  localparam int          RANDOM_PER_PHASE = 430;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [23:0]      vertex_type = 24'd0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  vld_pkg::offset_t wgt_ofs;
  vld_pkg::offset_t tex_ofs;
  vld_pkg::offset_t col_ofs;
  vld_pkg::offset_t nrm_ofs;
  vld_pkg::offset_t pos_ofs;
  logic [6:0]       stride;
  logic [3:0]       wgt_num;
  logic [3:0]       morph_num;
  logic             through_mode;
  logic [1:0]       index_code;
  logic             drawable;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned directed_count = 0;

  layout_scoreboard layouts = new();
  layout_t          got_layout;

  vertex_layout_decode_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .vertex_type  (vertex_type),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .wgt_ofs      (wgt_ofs),
    .tex_ofs      (tex_ofs),
    .col_ofs      (col_ofs),
    .nrm_ofs      (nrm_ofs),
    .pos_ofs      (pos_ofs),
    .stride       (stride),
    .wgt_num      (wgt_num),
    .morph_num    (morph_num),
    .through_mode (through_mode),
    .index_code   (index_code),
    .drawable     (drawable)
  );

  always #1 clk = ~clk;

  // build a vertex type word from its component codes and counts
  function automatic logic [23:0] pack_vertex_type(
    logic [1:0] wgt, logic [2:0] wcount_m1, logic [1:0] tex, logic [2:0] col,
    logic [1:0] nrm, logic [1:0] pos, logic [1:0] idx, logic [2:0] mcount_m1,
    logic thr);
    return {thr, 2'b00, mcount_m1, 1'b0, wcount_m1, 1'b0, idx, wgt, pos, nrm, col, tex};
  endfunction

  // offer one vertex type, wait for its transfer, then idle at random
  task automatic send_vertex(input logic [23:0] vt);
    in_valid    <= 1'b1;
    vertex_type <= vt;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    layouts.note(vt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid    <= 1'b0;
      vertex_type <= 24'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic send_directed(input logic [23:0] vt);
    send_vertex(vt);
    directed_count++;
  endtask

  // result side: check each transfer, then pick the next stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_layout.wgt_ofs      = wgt_ofs;
        got_layout.tex_ofs      = tex_ofs;
        got_layout.col_ofs      = col_ofs;
        got_layout.nrm_ofs      = nrm_ofs;
        got_layout.pos_ofs      = pos_ofs;
        got_layout.stride       = stride;
        got_layout.wgt_num      = wgt_num;
        got_layout.morph_num    = morph_num;
        got_layout.through_mode = through_mode;
        got_layout.index_code   = index_code;
        got_layout.drawable     = drawable;
        layouts.check(got_layout);
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // main sequence
  initial begin
    int phase;
    int n;
    int c;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every code, no position, reserved codes, unused bits
    tx_idle_pct = 35;
    rx_idle_pct = 85;
    send_directed(24'h000000);
    send_directed(24'hffffff);
    send_directed(pack_vertex_type(vld_pkg::SCALAR_FLOAT, 3'd7, vld_pkg::SCALAR_HALF,
                                   vld_pkg::COLOR_FULL, vld_pkg::SCALAR_BYTE, SCALAR_NONE,
                                   INDEX_RESERVED, 3'd7, 1'b1));
    send_directed(pack_vertex_type(SCALAR_NONE, 3'd0, SCALAR_NONE, COLOR_NONE, SCALAR_NONE,
                                   vld_pkg::SCALAR_BYTE, INDEX_NONE, 3'd0, 1'b0));
    send_directed(pack_vertex_type(SCALAR_NONE, 3'd0, SCALAR_NONE, COLOR_NONE, SCALAR_NONE,
                                   vld_pkg::SCALAR_HALF, INDEX_BYTE, 3'd0, 1'b0));
    send_directed(pack_vertex_type(SCALAR_NONE, 3'd0, SCALAR_NONE, COLOR_NONE, SCALAR_NONE,
                                   vld_pkg::SCALAR_FLOAT, INDEX_HALF, 3'd0, 1'b1));
    for (c = 0; c < 8; c++) begin
      send_directed(pack_vertex_type(vld_pkg::SCALAR_BYTE, 3'd0, vld_pkg::SCALAR_BYTE, 3'(c),
                                     SCALAR_NONE, vld_pkg::SCALAR_HALF, INDEX_BYTE, 3'(c),
                                     1'b0));
    end
    // widest layout, stride 68
    send_directed(pack_vertex_type(vld_pkg::SCALAR_FLOAT, 3'd7, vld_pkg::SCALAR_FLOAT,
                                   vld_pkg::COLOR_FULL, vld_pkg::SCALAR_FLOAT,
                                   vld_pkg::SCALAR_FLOAT, INDEX_HALF, 3'd7, 1'b1));
    // odd cursors that need padding before half and float parts
    send_directed(pack_vertex_type(vld_pkg::SCALAR_BYTE, 3'd0, vld_pkg::SCALAR_HALF,
                                   COLOR_PACKED, vld_pkg::SCALAR_FLOAT, vld_pkg::SCALAR_BYTE,
                                   INDEX_NONE, 3'd1, 1'b0));
    send_directed(pack_vertex_type(vld_pkg::SCALAR_BYTE, 3'd2, vld_pkg::SCALAR_BYTE,
                                   vld_pkg::COLOR_FULL, vld_pkg::SCALAR_HALF,
                                   vld_pkg::SCALAR_HALF, INDEX_BYTE, 3'd2, 1'b0));
    send_directed(pack_vertex_type(vld_pkg::SCALAR_HALF, 3'd4, SCALAR_NONE, COLOR_NONE,
                                   vld_pkg::SCALAR_BYTE, vld_pkg::SCALAR_FLOAT,
                                   INDEX_RESERVED, 3'd3, 1'b1));
    send_directed(pack_vertex_type(vld_pkg::SCALAR_BYTE, 3'd6, SCALAR_NONE, COLOR_NONE,
                                   vld_pkg::SCALAR_BYTE, vld_pkg::SCALAR_BYTE,
                                   INDEX_NONE, 3'd5, 1'b0));
    // unused bits set, with a byte position and alone with no position
    send_directed(UNUSED_BITS | pack_vertex_type(SCALAR_NONE, 3'd0, SCALAR_NONE, COLOR_NONE,
                                                 SCALAR_NONE, vld_pkg::SCALAR_BYTE,
                                                 INDEX_NONE, 3'd0, 1'b0));
    send_directed(UNUSED_BITS);

    // random vertex types under three idling patterns
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 35;
          rx_idle_pct = 85;
        end
        1: begin
          tx_idle_pct = 85;
          rx_idle_pct = 35;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_vertex(24'($urandom));
      end
    end
    in_valid <= 1'b0;

    // drain, then allow for the pipeline depth
    while (layouts.pending.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("sent %0d vertex types (%0d directed), checked %0d layouts",
             layouts.noted, directed_count, layouts.checked);
    $display("%0d drawable, %0d without position, %0d mismatches",
             layouts.drawn, layouts.checked - layouts.drawn, layouts.errors);
    if (layouts.errors == 0) begin
      $display("[vertex_layout_decode_unit] OK");
    end else begin
      $display("[vertex_layout_decode_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("timeout with %0d layouts still pending", layouts.pending.size());
    $display("[vertex_layout_decode_unit] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/vld_pkg.sv
rtl/vertex_layout_decode_unit.sv
rtl/vld_checker.sv
test/testbench.sv
